// ----- rtl/whdc_pkg.sv -----
// ----------------------------------------------------------------------------
// whdc_pkg: shared types for the 802.11 header device classifier
// Header and result word layouts, status, class, role and evidence codes.
// ----------------------------------------------------------------------------
package whdc_pkg;

  localparam int MacW = 48;

  // frame control layout
  localparam int FcToDsBit   = 8;
  localparam int FcFromDsBit = 9;
  localparam int MacGroupBit = 40;

  // length limits in bytes
  localparam logic [15:0] LenMin     = 16'd2;
  localparam logic [15:0] LenHdrMin  = 16'd24;
  localparam logic [15:0] LenWdsMin  = 16'd30;

  typedef enum logic [1:0] {
    TYPE_MGMT = 2'd0,
    TYPE_CTRL = 2'd1,
    TYPE_DATA = 2'd2,
    TYPE_RSVD = 2'd3
  } frame_type_t;

  typedef enum logic [3:0] {
    SUB_ASSOC_REQ    = 4'd0,
    SUB_ASSOC_RESP   = 4'd1,
    SUB_REASSOC_REQ  = 4'd2,
    SUB_REASSOC_RESP = 4'd3,
    SUB_PROBE_REQ    = 4'd4,
    SUB_PROBE_RESP   = 4'd5,
    SUB_BEACON       = 4'd8
  } mgmt_sub_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CL_OTHER = 2'd0,
    CL_MGMT  = 2'd1,
    CL_DATA  = 2'd2
  } class_t;

  typedef enum logic [2:0] {
    RL_NONE    = 3'd0,
    RL_AP      = 3'd1,
    RL_STA     = 3'd2,
    RL_PEER    = 3'd3,
    RL_UNKNOWN = 3'd4
  } role_t;

  typedef enum logic [1:0] {
    EV_ASSOC_REQ  = 2'd0,
    EV_ASSOC_RESP = 2'd1,
    EV_TO_DS      = 2'd2,
    EV_FROM_DS    = 2'd3
  } evidence_t;

  typedef struct packed {
    logic [15:0]       fctl;
    logic [15:0]       cap_len;
    logic [MacW-1:0]   addr_one;
    logic [MacW-1:0]   addr_two;
    logic signed [7:0] rssi_in;
    logic [7:0]        channel_in;
    logic [63:0]       time_ms_in;
  } hdr_word_t;

  typedef struct packed {
    status_t           status;
    class_t            pkt_class;
    logic [MacW-1:0]   primary_device;
    role_t             primary_role;
    logic [MacW-1:0]   secondary_device;
    role_t             secondary_role;
    logic              rel_found;
    evidence_t         relation_kind;
    logic signed [7:0] rssi_out;
    logic [7:0]        channel_out;
    logic [63:0]       time_ms_out;
  } res_word_t;

  // nonzero unicast address
  function automatic logic trackable(input logic [MacW-1:0] mac);
    trackable = (mac != '0) && !mac[MacGroupBit];
  endfunction

endpackage

// ----- rtl/whdc_classify.sv -----
// ----------------------------------------------------------------------------
// whdc_classify: header decode and device classification
// Pure combinational mapping of one header word to one result word.
// ----------------------------------------------------------------------------
module whdc_classify (
  input  whdc_pkg::hdr_word_t hdr,
  output whdc_pkg::res_word_t res
);

  whdc_pkg::frame_type_t ftype;
  logic [3:0]            sub;
  logic                  to_ds;
  logic                  from_ds;
  logic                  t1;
  logic                  t2;
  logic                  rel_ok;

  assign ftype   = whdc_pkg::frame_type_t'(hdr.fctl[3:2]);
  assign sub     = hdr.fctl[7:4];
  assign to_ds   = hdr.fctl[whdc_pkg::FcToDsBit];
  assign from_ds = hdr.fctl[whdc_pkg::FcFromDsBit];
  assign t1      = whdc_pkg::trackable(hdr.addr_one);
  assign t2      = whdc_pkg::trackable(hdr.addr_two);
  assign rel_ok  = t1 && t2 && (hdr.addr_one != hdr.addr_two);

  always_comb begin
    res                  = '0;
    res.status           = whdc_pkg::ST_MALFORMED;
    res.pkt_class        = whdc_pkg::CL_OTHER;
    res.primary_role     = whdc_pkg::RL_NONE;
    res.secondary_role   = whdc_pkg::RL_NONE;
    res.relation_kind    = whdc_pkg::EV_ASSOC_REQ;
    res.rssi_out         = hdr.rssi_in;
    res.channel_out      = hdr.channel_in;
    res.time_ms_out      = hdr.time_ms_in;

    priority if (hdr.cap_len < whdc_pkg::LenMin || hdr.fctl[1:0] != 2'd0) begin
      res.status = whdc_pkg::ST_MALFORMED;
    end else if (ftype == whdc_pkg::TYPE_CTRL || ftype == whdc_pkg::TYPE_RSVD) begin
      res.status = whdc_pkg::ST_IGNORED;
    end else if (hdr.cap_len < whdc_pkg::LenHdrMin) begin
      res.status = whdc_pkg::ST_MALFORMED;
    end else if (ftype == whdc_pkg::TYPE_DATA && to_ds && from_ds
                 && hdr.cap_len < whdc_pkg::LenWdsMin) begin
      res.status = whdc_pkg::ST_MALFORMED;
    end else begin
      // primary slot always follows address 2, secondary address 1
      if (ftype == whdc_pkg::TYPE_MGMT) begin
        res.pkt_class = whdc_pkg::CL_MGMT;
        priority case (sub)
          whdc_pkg::SUB_BEACON, whdc_pkg::SUB_PROBE_RESP: begin
            res.primary_role = whdc_pkg::RL_AP;
          end
          whdc_pkg::SUB_PROBE_REQ: begin
            res.primary_role = whdc_pkg::RL_STA;
          end
          whdc_pkg::SUB_ASSOC_REQ, whdc_pkg::SUB_REASSOC_REQ: begin
            res.primary_role   = whdc_pkg::RL_STA;
            res.secondary_role = whdc_pkg::RL_AP;
            res.rel_found      = rel_ok;
            res.relation_kind  = whdc_pkg::EV_ASSOC_REQ;
          end
          whdc_pkg::SUB_ASSOC_RESP, whdc_pkg::SUB_REASSOC_RESP: begin
            res.primary_role   = whdc_pkg::RL_AP;
            res.secondary_role = whdc_pkg::RL_STA;
            res.rel_found      = rel_ok;
            res.relation_kind  = whdc_pkg::EV_ASSOC_RESP;
          end
          default: begin
            res.primary_role = whdc_pkg::RL_UNKNOWN;
          end
        endcase
      end else begin
        res.pkt_class = whdc_pkg::CL_DATA;
        priority if (to_ds && !from_ds) begin
          res.primary_role   = whdc_pkg::RL_STA;
          res.secondary_role = whdc_pkg::RL_AP;
          res.rel_found      = rel_ok;
          res.relation_kind  = whdc_pkg::EV_TO_DS;
        end else if (!to_ds && from_ds) begin
          res.primary_role   = whdc_pkg::RL_AP;
          res.secondary_role = whdc_pkg::RL_STA;
          res.rel_found      = rel_ok;
          res.relation_kind  = whdc_pkg::EV_FROM_DS;
        end else begin
          res.primary_role = whdc_pkg::RL_PEER;
        end
      end

      // drop slots whose address cannot be tracked
      if (t2) begin
        res.primary_device = hdr.addr_two;
      end else begin
        res.primary_role = whdc_pkg::RL_NONE;
      end
      if (t1 && res.secondary_role != whdc_pkg::RL_NONE) begin
        res.secondary_device = hdr.addr_one;
      end else begin
        res.secondary_role = whdc_pkg::RL_NONE;
      end
      if (!res.rel_found) begin
        res.relation_kind = whdc_pkg::EV_ASSOC_REQ;
      end

      res.status = (res.primary_role != whdc_pkg::RL_NONE
                    || res.secondary_role != whdc_pkg::RL_NONE)
                   ? whdc_pkg::ST_OK : whdc_pkg::ST_IGNORED;
    end
  end

endmodule

// ----- rtl/wifi_header_device_classifier_top.sv -----
// ----------------------------------------------------------------------------
// wifi_header_device_classifier_top: 802.11 header device classifier
// Registers each header, classifies it and registers one result word.
// ----------------------------------------------------------------------------
// path: an accepted header passes the input register, then the decode and the
// result register, before it can leave on the result channel
// throughput: one header word per cycle, set by the single decode stage, while
// the result side is not stalled; the result register is its own stage, so a
// waiting result does not block a new header while the input register is free
// reset: synchronous active-high rst clears both valid flags; payload not reset
module wifi_header_device_classifier_top (
  input  logic                clk,
  input  logic                rst,
  // header channel
  input  logic                hdr_valid,
  output logic                hdr_stall,
  input  whdc_pkg::hdr_word_t hdr,
  // result channel
  output logic                res_valid,
  input  logic                res_stall,
  output whdc_pkg::res_word_t res
);

  // input register stage
  logic                s1_valid;
  whdc_pkg::hdr_word_t s1_hdr;

  // decoded result ahead of the result register
  whdc_pkg::res_word_t res_next;

  // result stage can load when empty or when its word leaves this cycle
  logic res_ready;

  assign res_ready = !res_valid || !res_stall;

  // hold the header side only when the input register is full and stuck
  assign hdr_stall = s1_valid && !res_ready;

  whdc_classify u_classify (
    .hdr (s1_hdr),
    .res (res_next)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_ready) begin
        res_valid <= s1_valid;
      end
      if (!hdr_stall) begin
        s1_valid <= hdr_valid;
      end
    end
  end

  // payload registers, loaded only when a word moves in
  always_ff @(posedge clk) begin
    if (hdr_valid && !hdr_stall) begin
      s1_hdr <= hdr;
    end
    if (s1_valid && res_ready) begin
      res <= res_next;
    end
  end

endmodule

// ----- rtl/whdc_chk.sv -----
// ----------------------------------------------------------------------------
// whdc_chk: port checker for the header device classifier
// Watches the top level ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
module whdc_chk (
  input logic                clk,
  input logic                rst,
  input logic                hdr_stall,
  input logic                res_valid,
  input logic                res_stall,
  input whdc_pkg::res_word_t res
);

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // the header side only backs up behind a held result word
  a_hdr_stall_cause: assert property (@(posedge clk) disable iff (rst)
    hdr_stall |-> res_valid && res_stall)
    else $error("header stalled without a held result");

  // ok needs at least one observed device
  a_ok_has_dev: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == whdc_pkg::ST_OK |->
      res.primary_role != whdc_pkg::RL_NONE || res.secondary_role != whdc_pkg::RL_NONE)
    else $error("ok status without a device");

  // a relation names two distinct tracked devices
  a_rel_devs: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.rel_found |->
      res.primary_role != whdc_pkg::RL_NONE && res.secondary_role != whdc_pkg::RL_NONE
      && res.primary_device != res.secondary_device)
    else $error("relation without two distinct devices");

  // malformed words carry no devices and no relation
  a_malformed_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == whdc_pkg::ST_MALFORMED |->
      res.pkt_class == whdc_pkg::CL_OTHER && !res.rel_found
      && res.primary_device == '0 && res.secondary_device == '0)
    else $error("malformed word carries devices");

endmodule

bind wifi_header_device_classifier_top whdc_chk u_whdc_chk (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: 802.11 header device classifier
// Drives header words through the valid/stall channel, predicts each result
// word from the header alone and checks every returned word field by field,
// with random idling on both sides, a long result hold-off and drain pauses.
// ----------------------------------------------------------------------------
module testbench;
  import whdc_pkg::*;

  localparam int ClkHalf       = 6;
  localparam int TimeoutCycles = 300000;
  localparam int LongHold      = 64;   // receiver hold-off that backs up the block
  localparam int SettleCycles  = 8;    // idle time after each drain
  localparam int RandomItems   = 750;

  // a management subtype outside the handled set (deauthentication)
  localparam logic [3:0] SubDeauth = 4'd12;

  // directed addresses: first octet in bits 47:40, group bit is bit 40
  localparam logic [MacW-1:0] StaMac   = 48'h02_11_22_33_44_55;
  localparam logic [MacW-1:0] ApMac    = 48'h0a_bb_cc_dd_ee_01;
  localparam logic [MacW-1:0] McastMac = 48'h01_00_5e_00_00_01;
  localparam logic [MacW-1:0] BcastMac = 48'hff_ff_ff_ff_ff_ff;

  // --------------------------------------------------------------------------
  // expected classification store and header predictor
  // --------------------------------------------------------------------------
  class classification_board;
    res_word_t   expected_words[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    // nonzero and not a group address
    function bit is_station(logic [MacW-1:0] mac);
      return (mac != '0) && (mac[MacGroupBit] == 1'b0);
    endfunction

    function void fill_primary(inout res_word_t r, input logic [MacW-1:0] mac,
                               input role_t role);
      if (is_station(mac)) begin
        r.primary_device = mac;
        r.primary_role   = role;
      end
    endfunction

    function void fill_secondary(inout res_word_t r, input logic [MacW-1:0] mac,
                                 input role_t role);
      if (is_station(mac)) begin
        r.secondary_device = mac;
        r.secondary_role   = role;
      end
    endfunction

    function void fill_relation(inout res_word_t r, input logic [MacW-1:0] client,
                                input logic [MacW-1:0] bssid, input evidence_t ev);
      if (is_station(client) && is_station(bssid) && client != bssid) begin
        r.rel_found     = 1'b1;
        r.relation_kind = ev;
      end
    endfunction

    function res_word_t classify(hdr_word_t h);
      res_word_t   r;
      frame_type_t ftype;
      logic [3:0]  sub;
      logic        to_ds;
      logic        from_ds;
      r           = '0;
      r.status      = ST_MALFORMED;
      r.pkt_class   = CL_OTHER;
      r.rssi_out    = h.rssi_in;
      r.channel_out = h.channel_in;
      r.time_ms_out = h.time_ms_in;
      ftype   = frame_type_t'(h.fctl[3:2]);
      sub     = h.fctl[7:4];
      to_ds   = h.fctl[FcToDsBit];
      from_ds = h.fctl[FcFromDsBit];
      if (h.cap_len < LenMin || h.fctl[1:0] != 2'b00) begin
        r.status = ST_MALFORMED;
      end else if (ftype == TYPE_CTRL || ftype == TYPE_RSVD) begin
        r.status = ST_IGNORED;
      end else if (h.cap_len < LenHdrMin) begin
        r.status = ST_MALFORMED;
      end else if (ftype == TYPE_MGMT) begin
        r.pkt_class = CL_MGMT;
        case (sub)
          SUB_BEACON, SUB_PROBE_RESP: begin
            fill_primary(r, h.addr_two, RL_AP);
          end
          SUB_PROBE_REQ: begin
            fill_primary(r, h.addr_two, RL_STA);
          end
          SUB_ASSOC_REQ, SUB_REASSOC_REQ: begin
            fill_primary(r, h.addr_two, RL_STA);
            fill_secondary(r, h.addr_one, RL_AP);
            fill_relation(r, h.addr_two, h.addr_one, EV_ASSOC_REQ);
          end
          SUB_ASSOC_RESP, SUB_REASSOC_RESP: begin
            fill_primary(r, h.addr_two, RL_AP);
            fill_secondary(r, h.addr_one, RL_STA);
            fill_relation(r, h.addr_one, h.addr_two, EV_ASSOC_RESP);
          end
          default: begin
            fill_primary(r, h.addr_two, RL_UNKNOWN);
          end
        endcase
        r.status = (r.primary_role != RL_NONE || r.secondary_role != RL_NONE) ?
                   ST_OK : ST_IGNORED;
      end else if (to_ds && from_ds && h.cap_len < LenWdsMin) begin
        r.status = ST_MALFORMED;
      end else begin
        r.pkt_class = CL_DATA;
        if (to_ds && !from_ds) begin
          fill_primary(r, h.addr_two, RL_STA);
          fill_secondary(r, h.addr_one, RL_AP);
          fill_relation(r, h.addr_two, h.addr_one, EV_TO_DS);
        end else if (!to_ds && from_ds) begin
          fill_primary(r, h.addr_two, RL_AP);
          fill_secondary(r, h.addr_one, RL_STA);
          fill_relation(r, h.addr_one, h.addr_two, EV_FROM_DS);
        end else begin
          fill_primary(r, h.addr_two, RL_PEER);
        end
        r.status = (r.primary_role != RL_NONE || r.secondary_role != RL_NONE) ?
                   ST_OK : ST_IGNORED;
      end
      return r;
    endfunction

    function void note_header(hdr_word_t h);
      expected_words.push_back(classify(h));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(res_word_t got);
      res_word_t want;
      if (expected_words.size() == 0) begin
        failures++;
        $display("%0t result word with nothing expected: %h", $time, got);
        return;
      end
      want = expected_words.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("pkt_class", 64'(want.pkt_class), 64'(got.pkt_class));
      compare_field("primary_device", 64'(want.primary_device),
                    64'(got.primary_device));
      compare_field("primary_role", 64'(want.primary_role), 64'(got.primary_role));
      compare_field("secondary_device", 64'(want.secondary_device),
                    64'(got.secondary_device));
      compare_field("secondary_role", 64'(want.secondary_role),
                    64'(got.secondary_role));
      compare_field("rel_found", 64'(want.rel_found), 64'(got.rel_found));
      compare_field("relation_kind", 64'(want.relation_kind), 64'(got.relation_kind));
      compare_field("rssi_out", 64'($unsigned(want.rssi_out)),
                    64'($unsigned(got.rssi_out)));
      compare_field("channel_out", 64'(want.channel_out), 64'(got.channel_out));
      compare_field("time_ms_out", want.time_ms_out, got.time_ms_out);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst       = 1'b1;
  logic      hdr_valid = 1'b0;
  logic      hdr_stall;
  hdr_word_t hdr       = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_word_t res;

  // idling controls shared between the sender, the receiver and the sequence
  bit tx_burst      = 1'b0;  // sender offers back to back
  bit rx_burst      = 1'b0;  // receiver adds no random stalls
  bit hold_results  = 1'b0;  // request for one long receiver hold-off

  classification_board board = new();

  initial begin
    clk = 1'b0;
    forever #ClkHalf clk = ~clk;
  end

  wifi_header_device_classifier_top u_top (
    .clk       (clk),
    .rst       (rst),
    .hdr_valid (hdr_valid),
    .hdr_stall (hdr_stall),
    .hdr       (hdr),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // --------------------------------------------------------------------------
  // monitors: both channels sampled at the edge that completes the handshake
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (hdr_valid && !hdr_stall) board.note_header(hdr);
      if (res_valid === 1'b1 && !res_stall) board.check_result(res);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // frame control with version zero
  function automatic logic [15:0] make_fc(frame_type_t t, logic [3:0] sub,
                                          logic to_ds, logic from_ds);
    logic [15:0] fc;
    fc              = '0;
    fc[3:2]         = t;
    fc[7:4]         = sub;
    fc[FcToDsBit]   = to_ds;
    fc[FcFromDsBit] = from_ds;
    return fc;
  endfunction

  // header with random capture metadata
  function automatic hdr_word_t build_header(logic [15:0] fc, logic [15:0] len,
                                             logic [MacW-1:0] a1,
                                             logic [MacW-1:0] a2);
    hdr_word_t h;
    h.fctl        = fc;
    h.cap_len     = len;
    h.addr_one    = a1;
    h.addr_two    = a2;
    h.rssi_in     = 8'($urandom);
    h.channel_in  = 8'($urandom);
    h.time_ms_in  = {$urandom, $urandom};
    return h;
  endfunction

  // mostly unicast, some zero, group, repeated or fully random addresses
  function automatic logic [MacW-1:0] pick_address(logic [MacW-1:0] other);
    int unsigned     pick;
    logic [MacW-1:0] mac;
    pick = $urandom_range(0, 99);
    mac  = {16'($urandom), $urandom};
    if (pick < 70) mac[MacGroupBit] = 1'b0;
    else if (pick < 78) mac = '0;
    else if (pick < 88) mac[MacGroupBit] = 1'b1;
    else if (pick < 96) mac = other;
    return mac;
  endfunction

  function automatic hdr_word_t random_header();
    hdr_word_t   h;
    int unsigned shape;
    frame_type_t ftype;
    h = build_header(16'($urandom), 16'($urandom), '0, '0);
    h.addr_one = pick_address({16'($urandom), $urandom});
    h.addr_two = pick_address(h.addr_one);
    shape = $urandom_range(0, 99);
    if (shape < 82) begin
      // well-formed header: version zero, management or data
      h.fctl[1:0] = 2'b00;
      ftype = $urandom_range(0, 1) ? TYPE_DATA : TYPE_MGMT;
      h.fctl[3:2] = ftype;
      if (ftype == TYPE_MGMT && $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 6))
          0: h.fctl[7:4] = SUB_ASSOC_REQ;
          1: h.fctl[7:4] = SUB_ASSOC_RESP;
          2: h.fctl[7:4] = SUB_REASSOC_REQ;
          3: h.fctl[7:4] = SUB_REASSOC_RESP;
          4: h.fctl[7:4] = SUB_PROBE_REQ;
          5: h.fctl[7:4] = SUB_PROBE_RESP;
          default: h.fctl[7:4] = SUB_BEACON;
        endcase
      end
      case ($urandom_range(0, 9))
        0: h.cap_len = 16'($urandom_range(20, 31));   // around both length limits
        1: h.cap_len = 16'($urandom);
        default: h.cap_len = 16'($urandom_range(24, 1600));
      endcase
    end else if (shape < 90) begin
      h.cap_len = 16'($urandom_range(0, 31));
    end
    // otherwise every field stays fully random
    return h;
  endfunction

  // offer one header word after a random gap, hold it until taken
  task automatic drive_header(hdr_word_t h);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      hdr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hdr       <= h;
    hdr_valid <= 1'b1;
    do @(posedge clk); while (hdr_stall !== 1'b0);
  endtask

  // stop offering until every expected result word is back
  task automatic drain_results();
    hdr_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stall before each result word, one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    int          hold;
    int unsigned results_taken;
    results_taken = 0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        hold = LongHold;
      end else begin
        hold = rx_burst ? 0 : $urandom_range(0, 4);
      end
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        res_stall <= 1'b0;
      end
      do @(posedge clk); while (res_valid !== 1'b1);
      results_taken++;
      if (results_taken % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    hdr_word_t h;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // length below two bytes, even with a good beacon layout
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_BEACON, 1'b0, 1'b0),
                              16'd0, BcastMac, ApMac));
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_BEACON, 1'b0, 1'b0),
                              16'd1, BcastMac, ApMac));
    // nonzero protocol version
    h = build_header(make_fc(TYPE_DATA, 4'd0, 1'b1, 1'b0), 16'd100, ApMac, StaMac);
    h.fctl[1:0] = 2'b01;
    drive_header(h);
    h.fctl[1:0] = 2'b11;
    drive_header(h);
    // control and reserved types are dropped
    drive_header(build_header(make_fc(TYPE_CTRL, 4'd11, 1'b0, 1'b0),
                              16'd100, ApMac, StaMac));
    drive_header(build_header(make_fc(TYPE_RSVD, 4'd0, 1'b1, 1'b1),
                              16'd100, ApMac, StaMac));
    // short management header
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_BEACON, 1'b0, 1'b0),
                              16'd23, BcastMac, ApMac));
    // each management subtype
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_BEACON, 1'b0, 1'b0),
                              16'd24, BcastMac, ApMac));
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_PROBE_RESP, 1'b0, 1'b0),
                              16'd60, StaMac, ApMac));
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_PROBE_REQ, 1'b0, 1'b0),
                              16'd40, BcastMac, StaMac));
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_ASSOC_REQ, 1'b0, 1'b0),
                              16'd80, ApMac, StaMac));
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_REASSOC_REQ, 1'b0, 1'b0),
                              16'd80, ApMac, StaMac));
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_ASSOC_RESP, 1'b0, 1'b0),
                              16'd80, StaMac, ApMac));
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_REASSOC_RESP, 1'b0, 1'b0),
                              16'd80, StaMac, ApMac));
    drive_header(build_header(make_fc(TYPE_MGMT, SubDeauth, 1'b0, 1'b0),
                              16'd26, StaMac, ApMac));
    // data frames in every direction
    drive_header(build_header(make_fc(TYPE_DATA, 4'd0, 1'b1, 1'b0),
                              16'd200, ApMac, StaMac));
    drive_header(build_header(make_fc(TYPE_DATA, 4'd8, 1'b0, 1'b1),
                              16'd200, StaMac, ApMac));
    drive_header(build_header(make_fc(TYPE_DATA, 4'd0, 1'b0, 1'b0),
                              16'd24, StaMac, ApMac));
    // four-address data just below and at its minimum length
    drive_header(build_header(make_fc(TYPE_DATA, 4'd0, 1'b1, 1'b1),
                              16'd29, StaMac, ApMac));
    drive_header(build_header(make_fc(TYPE_DATA, 4'd0, 1'b1, 1'b1),
                              16'd30, StaMac, ApMac));
    // same address twice: both devices, no relation
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_ASSOC_REQ, 1'b0, 1'b0),
                              16'd80, StaMac, StaMac));
    // group bssid: client only, no relation
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_ASSOC_REQ, 1'b0, 1'b0),
                              16'd80, McastMac, StaMac));
    // zero transmitter: nothing trackable, class kept
    drive_header(build_header(make_fc(TYPE_MGMT, SUB_BEACON, 1'b0, 1'b0),
                              16'd24, BcastMac, '0));
    // all-ones fields and metadata maxima
    h = build_header(make_fc(TYPE_DATA, 4'd0, 1'b1, 1'b0), 16'hffff, BcastMac, BcastMac);
    h.rssi_in    = 8'sd127;
    h.channel_in = 8'hff;
    h.time_ms_in = '1;
    drive_header(h);
    // metadata minima
    h = build_header(make_fc(TYPE_DATA, 4'd0, 1'b0, 1'b1), 16'd24, StaMac, ApMac);
    h.rssi_in    = -8'sd128;
    h.channel_in = 8'h00;
    h.time_ms_in = '0;
    drive_header(h);
    drain_results();

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      // back up the block behind a long receiver hold-off
      if (i == 250) begin
        tx_burst     = 1'b1;
        hold_results = 1'b1;
      end
      // sender pause with the pipeline emptied
      if (i == 500) drain_results();
      drive_header(random_header());
    end
    drain_results();

    if (board.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TimeoutCycles * 2 * ClkHalf);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
